// ===== src/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants for the lift bridge sequencer.
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CODE_W     = 4;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned S_TUSER_W  = 4;
    localparam int unsigned M_TDATA_W  = 48;

    localparam logic [TIME_W-1:0] HOLD_TIMEOUT_RESET = 32'd30000;

    typedef enum logic [CODE_W-1:0] {
        ST_INIT     = 4'd0,
        ST_IDLE     = 4'd1,
        ST_CLEARING = 4'd2,
        ST_RAISING  = 4'd3,
        ST_HOLD     = 4'd4,
        ST_LOWERING = 4'd5,
        ST_OPENING  = 4'd6,
        ST_FAULT    = 4'd7,
        ST_ESTOP    = 4'd8
    } state_t;

    typedef enum logic [CODE_W-1:0] {
        EV_ESTOP_ON   = 4'd0,
        EV_ESTOP_OFF  = 4'd1,
        EV_FAULT_ON   = 4'd2,
        EV_FAULT_OFF  = 4'd3,
        EV_TICK       = 4'd4,
        EV_VEHICLE    = 4'd5,
        EV_RAISE      = 4'd6,
        EV_LOWER      = 4'd7,
        EV_HOLD       = 4'd8,
        EV_CW_READY   = 4'd9,
        EV_BAR_CLOSED = 4'd10,
        EV_BAR_OPEN   = 4'd11,
        EV_TOP        = 4'd12,
        EV_BOTTOM     = 4'd13
    } event_t;

    // init_done sits in the lowest bit
    typedef struct packed {
        logic estop_clearable;
        logic road_opened;
        logic road_clear;
        logic may_clear_road;
        logic init_done;
    } guard_t;

    typedef struct packed {
        state_t            state;
        state_t            last_state;
        logic [TIME_W-1:0] entry_time;
        logic              weight_ready;
    } seq_ctx_t;

    typedef struct packed {
        seq_ctx_t ctx;
        logic     changed;
    } step_res_t;

endpackage

// ===== src/lbs_step.sv =====
// ----------------------------------------------------------------------------
// lbs_step
// Next-state function: one event applied to the sequencer context.
// ----------------------------------------------------------------------------
module lbs_step (
    input  lbs_pkg::seq_ctx_t          ctx_i,
    input  logic [lbs_pkg::CODE_W-1:0] event_code_i,
    input  logic [lbs_pkg::TIME_W-1:0] now_i,
    input  lbs_pkg::guard_t            guard_i,
    input  logic [lbs_pkg::TIME_W-1:0] hold_timeout_i,
    output lbs_pkg::step_res_t         res_o
);
    import lbs_pkg::*;

    state_t            target;
    logic              take;
    logic              cw;
    logic              changed;
    logic [TIME_W-1:0] age;

    always_comb begin
        target = ctx_i.state;
        take   = 1'b0;
        cw     = ctx_i.weight_ready;
        age    = now_i - ctx_i.entry_time;  // wraps mod 2^32

        if (event_code_i == EV_ESTOP_ON) begin
            target = ST_ESTOP;
            take   = 1'b1;
        end else if (event_code_i == EV_FAULT_ON && ctx_i.state != ST_ESTOP) begin
            target = ST_FAULT;
            take   = 1'b1;
        end else begin
            unique case (ctx_i.state)
                ST_INIT: begin
                    if (event_code_i == EV_TICK && guard_i.init_done) begin
                        target = ST_IDLE;
                        take   = 1'b1;
                    end
                end
                ST_IDLE: begin
                    if ((event_code_i == EV_VEHICLE && guard_i.may_clear_road) ||
                        event_code_i == EV_RAISE) begin
                        target = ST_CLEARING;
                        take   = 1'b1;
                    end
                end
                ST_CLEARING: begin
                    if (event_code_i == EV_CW_READY) begin
                        cw = 1'b1;
                    end
                    // flag updated above counts for this same event
                    if ((event_code_i == EV_BAR_CLOSED || event_code_i == EV_CW_READY ||
                         event_code_i == EV_TICK) && guard_i.road_clear && cw) begin
                        target = ST_RAISING;
                        take   = 1'b1;
                    end
                end
                ST_RAISING: begin
                    if (event_code_i == EV_TOP || event_code_i == EV_HOLD) begin
                        target = ST_HOLD;
                        take   = 1'b1;
                    end
                end
                ST_HOLD: begin
                    if (event_code_i == EV_LOWER) begin
                        target = ST_LOWERING;
                        take   = 1'b1;
                    end else if (event_code_i == EV_RAISE) begin
                        target = ST_RAISING;
                        take   = 1'b1;
                    end else if (event_code_i == EV_TICK && age >= hold_timeout_i) begin
                        target = ST_LOWERING;
                        take   = 1'b1;
                    end
                end
                ST_LOWERING: begin
                    if (event_code_i == EV_BOTTOM) begin
                        target = ST_OPENING;
                        take   = 1'b1;
                    end else if (event_code_i == EV_HOLD) begin
                        target = ST_HOLD;
                        take   = 1'b1;
                    end
                end
                ST_OPENING: begin
                    if ((event_code_i == EV_BAR_OPEN || event_code_i == EV_TICK) &&
                        guard_i.road_opened) begin
                        target = ST_IDLE;
                        take   = 1'b1;
                    end
                end
                ST_FAULT: begin
                    if (event_code_i == EV_FAULT_OFF) begin
                        target = ST_IDLE;
                        take   = 1'b1;
                    end
                end
                ST_ESTOP: begin
                    if (event_code_i == EV_ESTOP_OFF && guard_i.estop_clearable) begin
                        target = ST_IDLE;
                        take   = 1'b1;
                    end
                end
                default: begin
                    // unreachable codes react only to estop and fault
                end
            endcase
        end

        // a move to the state already held is no transition
        changed = take && (target != ctx_i.state);

        res_o.ctx              = ctx_i;
        res_o.ctx.weight_ready = cw;
        res_o.changed          = changed;
        if (changed) begin
            res_o.ctx.last_state = ctx_i.state;
            res_o.ctx.state      = target;
            res_o.ctx.entry_time = now_i;
            if (target == ST_CLEARING) begin
                res_o.ctx.weight_ready = 1'b0;
            end
        end
    end

endmodule

// ===== src/lift_bridge_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// lift_bridge_sequencer_core
// Nine-state lift bridge sequencer, one event per item, one status per item.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                  Payload
//  s_axis    in   s_axis_tvalid/tready       event code (tuser), time + guards
//  m_axis    out  m_axis_tvalid/tready       state, prev, changed, entry time
//  cfg       in   cfg_wr_en (no back-press)  hold timeout in ms
//
//  One item per cycle sustained while m_axis_tready stays high; m_axis_tvalid rises
//  after the s_axis accept via the input register, then the step logic into the result register.
//  The sequencer context updates in the cycle an item moves into the result
//  register, so the next item in the input register already sees it.
//  m_axis_tready low holds the result; the input register still takes one
//  more item, then s_axis_tready drops until the result is taken.
//  aresetn (synchronous, active low) puts the sequencer in init, timeout 30000.
// ----------------------------------------------------------------------------
module lift_bridge_sequencer_core (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] now_ms, [32] guard_init_done, [33] guard_may_clear_road,
    // [34] guard_road_clear, [35] guard_road_opened,
    // [36] guard_estop_clearable, [39:37] zero
    input  logic [lbs_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [3:0] event_code
    input  logic [lbs_pkg::S_TUSER_W-1:0]    s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [3:0] current_state, [7:4] previous_state, [8] state_changed,
    // [40:9] entered_at_ms, [47:41] zero
    output logic [lbs_pkg::M_TDATA_W-1:0]    m_axis_tdata,

    input  logic                             cfg_wr_en,
    input  logic [lbs_pkg::TIME_W-1:0]       cfg_wr_data
);
    import lbs_pkg::*;

    // input register
    logic                 in_valid_reg,  in_valid_next;
    logic [CODE_W-1:0]    in_event_reg;
    logic [TIME_W-1:0]    in_now_reg;
    guard_t               in_guard_reg;

    // sequencer context and config
    seq_ctx_t             ctx_reg,       ctx_next;
    logic [TIME_W-1:0]    timeout_reg;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg,  out_data_next;

    logic                 s_accept;
    logic                 advance;
    logic                 proc;
    step_res_t            step_res;

    // the result slot frees when empty or being taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    lbs_step u_step (
        .ctx_i          (ctx_reg),
        .event_code_i   (in_event_reg),
        .now_i          (in_now_reg),
        .guard_i        (in_guard_reg),
        .hold_timeout_i (timeout_reg),
        .res_o          (step_res)
    );

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (proc ? 1'b0 : in_valid_reg);
        out_valid_next = proc ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
        ctx_next       = proc ? step_res.ctx : ctx_reg;
        out_data_next  = {7'd0,
                          step_res.ctx.entry_time,
                          step_res.changed,
                          step_res.ctx.last_state,
                          step_res.ctx.state};
    end

    // control and context
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            ctx_reg.state          <= ST_INIT;
            ctx_reg.last_state     <= ST_INIT;
            ctx_reg.entry_time     <= '0;
            ctx_reg.weight_ready   <= 1'b0;
            timeout_reg            <= HOLD_TIMEOUT_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            ctx_reg       <= ctx_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_event_reg <= s_axis_tuser;
            in_now_reg   <= s_axis_tdata[TIME_W-1:0];
            in_guard_reg <= guard_t'(s_axis_tdata[TIME_W+4:TIME_W]);
        end
        if (proc) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a reported change always leaves current and previous apart
    a_change_differs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[3:0] != m_axis_tdata[7:4]))
        else $error("change reported with equal current and previous state");

    // an item stepped this cycle shows up as a result next cycle
    a_step_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        proc |=> out_valid_reg)
        else $error("stepped item lost before result register");

    // input back-pressure only with both registers full and the sink stalled
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    // a transition stamps the entry time with the item's timestamp
    a_entry_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && step_res.changed) |=> (ctx_reg.entry_time == $past(in_now_reg)))
        else $error("entry time not taken from the transition item");

    // context moves only when an item is stepped
    a_ctx_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !proc |=> $stable(ctx_reg))
        else $error("sequencer context changed without an item");

endmodule
